// ===== src/fbm_pkg.sv =====
package fbm_pkg;

    localparam int unsigned CFG_W = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUGHNESS = 1'd1;
    localparam logic [3:0] OCT_RESET = 4'd4;
    localparam logic [15:0] ROUGH_RESET = 16'd32768;
    localparam int unsigned OUT_W = 22;

    function automatic logic [7:0] perm_at(input logic [7:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
                8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
                8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
                8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
                8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
                8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
                8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
                8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
                8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
                8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
                8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
                8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
                8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
                8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
                8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
                8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
                8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
                8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
                8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
                8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
                8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
                8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
                8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
                8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
                8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
                8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
                8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
                8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
                8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
                8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
                8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
                8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
                8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
                8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
                8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
                8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
                8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
                8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
                8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
                8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
                8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
                8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
                8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
                8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
                8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
                8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
                8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
                8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
                8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
                8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
                8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
                8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
                8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
                8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
                8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
                8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
                8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
                8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
                8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
                8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
                8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
                8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
                8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
                8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
                default: r = 8'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/fbm_gradient_noise_2d_core.sv =====
// fBM gradient noise, 2D. Each accepted (x_coord, z_coord) transfer yields one
// noise_sum: octave_count (clamped to MAX_OCTAVES, zero gives 0) octaves of
// Perlin-style noise, octave i sampling the coordinate shifted left by i, weighted
// by an amplitude that starts at 1.0 and is scaled by roughness per octave; the
// sum saturates to 22 bits. All octaves run in parallel lanes of a 7-stage noise
// pipeline followed by one weighting stage and one output register, so the block
// accepts one transfer per clock while the output is not stalled. A downstream
// stall freezes the whole pipeline; a skid-free global enable keeps order.
// Configuration must only be written while the pipeline is empty. The octave
// amplitudes after the first are registered, one per octave, and settle after
// a roughness write, before a transfer accepted after the write reaches its
// weighting stage.
module fbm_gradient_noise_2d_core #(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [fbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbm_pkg::CFG_W-1:0]     cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] z_coord,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [fbm_pkg::OUT_W-1:0] noise_sum
);
    localparam int DEPTH = 9;           // 7 octave stages + weight + output
    localparam int SUM_W = FRAC_BITS + 12;
    localparam int CW = FRAC_BITS + 8;
    localparam int OW = fbm_pkg::OUT_W;
    localparam longint OUT_MAX = 2097151;
    localparam longint OUT_MIN = -2097152;

    logic [3:0]  oct_reg;
    logic [15:0] rough_reg;
    logic [DEPTH-1:0] vld_reg;
    logic en;

    // pipeline advances unless the output holds a stalled result
    assign en = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg   <= fbm_pkg::OCT_RESET;
            rough_reg <= fbm_pkg::ROUGH_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fbm_pkg::REG_OCTAVE_COUNT)
            begin
                oct_reg <= cfg_data[3:0];
            end
            else if (cfg_index == fbm_pkg::REG_ROUGHNESS)
            begin
                rough_reg <= cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    // amplitudes depend only on configuration; one multiply per register so the
    // chain settles over several cycles while no transfer is in flight
    logic [FRAC_BITS:0] amp [MAX_OCTAVES];
    assign amp[0] = (FRAC_BITS+1)'(1) << FRAC_BITS;
    genvar g;
    generate
        for (g = 1; g < MAX_OCTAVES; g++)
        begin : g_amp
            logic [FRAC_BITS+16:0] amp_p;
            logic [FRAC_BITS:0] amp_reg;
            assign amp_p = amp[g-1] * rough_reg;
            always_ff @(posedge clk)
            begin
                amp_reg <= amp_p[FRAC_BITS+16:16];
            end
            assign amp[g] = amp_reg;
        end
    endgenerate

    logic signed [SUM_W-1:0] part [MAX_OCTAVES+1];
    logic [4:0] cnt;
    assign cnt = ({1'b0, oct_reg} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : {1'b0, oct_reg};
    assign part[0] = '0;

    // the octave values all arrive in the same cycle; each lane weights its
    // own value in one weighting stage, and part[] adds the lanes combinationally
    logic signed [FRAC_BITS+3:0] oval [MAX_OCTAVES];
    logic signed [SUM_W-1:0] wsum [MAX_OCTAVES];
    generate
        for (g = 0; g < MAX_OCTAVES; g++)
        begin : g_oct
            logic [31:0] xsh, zsh;
            assign xsh = x_coord << g;
            assign zsh = z_coord << g;
            fbm_octave #(.FRAC_BITS(FRAC_BITS)) u_oct (
                .clk(clk), .en(en),
                .xs(xsh[CW-1:0]), .zs(zsh[CW-1:0]), .val(oval[g])
            );
            fbm_accum #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_acc (
                .clk(clk), .en(en), .use_oct(5'(g) < cnt),
                .val(oval[g]), .amp(amp[g]), .sum_in('0), .sum_out(wsum[g])
            );
            assign part[g+1] = part[g] + wsum[g];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (part[MAX_OCTAVES] > SUM_W'(OUT_MAX))
            begin
                noise_sum <= OW'(OUT_MAX);
            end
            else if (part[MAX_OCTAVES] < SUM_W'(OUT_MIN))
            begin
                noise_sum <= OW'(OUT_MIN);
            end
            else
            begin
                noise_sum <= part[MAX_OCTAVES][OW-1:0];
            end
        end
    end

    a_out_follows_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##0 en)
        else $error("input accepted while pipeline frozen");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(noise_sum)))
        else $error("stalled result changed");
    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while output stalled");
endmodule

// ===== src/fbm_octave.sv =====
// One noise octave, fully pipelined; all stages advance on en.
// Input: shifted coordinate low FRAC_BITS+8 bits. Output: octave value (Q.FRAC_BITS).
module fbm_octave #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [FRAC_BITS+7:0]   xs,
    input  logic [FRAC_BITS+7:0]   zs,
    output logic signed [FRAC_BITS+3:0] val
);
    localparam int F = FRAC_BITS;
    localparam int W = F + 6;                    // working signed width, fade needs +-15.0
    localparam int PW = 2 * W;
    localparam longint ONE = 64'sd1 << F;
    localparam longint OFF = ((64'd69 << F) + 64'd50) / 64'd100;
    localparam longint RCP = ((64'd1000 << F) + 64'd741) / 64'd1483;

    typedef logic signed [W-1:0] sv_t;
    typedef logic signed [PW-1:0] sp_t;

    function automatic sv_t fmul(input sv_t a, input sv_t b);
        sp_t p;
        begin
            p = sp_t'(a) * sp_t'(b);
            return sv_t'(p >>> F);
        end
    endfunction

    function automatic sv_t grad(input logic [3:0] h, input sv_t dx, input sv_t dz);
        sv_t u;
        sv_t v;
        begin
            u = (h < 4'd8) ? dx : dz;
            v = (h < 4'd4) ? dz : ((h == 4'd12 || h == 4'd14) ? dx : sv_t'(0));
            return (h[0] ? -u : u) + (h[1] ? -v : v);
        end
    endfunction

    // low hash bits of the second lookup
    function automatic logic [3:0] hash_lo(input logic [7:0] idx);
        logic [7:0] r;
        begin
            r = fbm_pkg::perm_at(idx);
            return r[3:0];
        end
    endfunction

    // stage 1: first hash level, fade partials
    logic [7:0] a1_reg, b1_reg;
    sv_t fx1_reg, fz1_reg, ix1_reg, iz1_reg, tt_x1_reg, tt_z1_reg;
    // stage 2
    logic [7:0] paa2_reg, pab2_reg, pba2_reg, pbb2_reg;
    sv_t fx2_reg, fz2_reg, inx2_reg, inz2_reg, t3x2_reg, t3z2_reg;
    // stage 3: hashes and fades
    logic [3:0] haa3_reg, hab3_reg, hba3_reg, hbb3_reg;
    sv_t fx3_reg, fz3_reg, u3_reg, v3_reg;
    // stage 4: gradients
    sv_t gaa4_reg, gba4_reg, gab4_reg, gbb4_reg, u4_reg, v4_reg;
    // stage 5: x lerps
    sv_t l05_reg, l15_reg, v5_reg;
    // stage 6: z lerp + offset
    sv_t r6_reg;

    logic [7:0] cx, cz;
    sv_t fx, fz;
    sv_t vnext;
    assign cx = xs[F+7:F];
    assign cz = zs[F+7:F];
    assign fx = sv_t'({1'b0, xs[F-1:0]});
    assign fz = sv_t'({1'b0, zs[F-1:0]});
    assign vnext = (fmul(r6_reg, sv_t'(RCP)) <<< 1) - sv_t'(ONE);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= fbm_pkg::perm_at(cx) + cz;
            b1_reg   <= fbm_pkg::perm_at(cx + 8'd1) + cz;
            fx1_reg  <= fx;
            fz1_reg  <= fz;
            ix1_reg  <= fmul(fx, sv_t'(6) * fx - sv_t'(15 * ONE));
            iz1_reg  <= fmul(fz, sv_t'(6) * fz - sv_t'(15 * ONE));
            tt_x1_reg <= fmul(fx, fx);
            tt_z1_reg <= fmul(fz, fz);

            paa2_reg <= fbm_pkg::perm_at(a1_reg);
            pab2_reg <= fbm_pkg::perm_at(a1_reg + 8'd1);
            pba2_reg <= fbm_pkg::perm_at(b1_reg);
            pbb2_reg <= fbm_pkg::perm_at(b1_reg + 8'd1);
            fx2_reg  <= fx1_reg;
            fz2_reg  <= fz1_reg;
            inx2_reg <= ix1_reg + sv_t'(10 * ONE);
            inz2_reg <= iz1_reg + sv_t'(10 * ONE);
            t3x2_reg <= fmul(tt_x1_reg, fx1_reg);
            t3z2_reg <= fmul(tt_z1_reg, fz1_reg);

            haa3_reg <= hash_lo(paa2_reg);
            hab3_reg <= hash_lo(pab2_reg);
            hba3_reg <= hash_lo(pba2_reg);
            hbb3_reg <= hash_lo(pbb2_reg);
            fx3_reg  <= fx2_reg;
            fz3_reg  <= fz2_reg;
            u3_reg   <= fmul(t3x2_reg, inx2_reg);
            v3_reg   <= fmul(t3z2_reg, inz2_reg);

            gaa4_reg <= grad(haa3_reg, fx3_reg, fz3_reg);
            gba4_reg <= grad(hba3_reg, fx3_reg - sv_t'(ONE), fz3_reg);
            gab4_reg <= grad(hab3_reg, fx3_reg, fz3_reg - sv_t'(ONE));
            gbb4_reg <= grad(hbb3_reg, fx3_reg - sv_t'(ONE), fz3_reg - sv_t'(ONE));
            u4_reg   <= u3_reg;
            v4_reg   <= v3_reg;

            l05_reg  <= gaa4_reg + fmul(u4_reg, gba4_reg - gaa4_reg);
            l15_reg  <= gab4_reg + fmul(u4_reg, gbb4_reg - gab4_reg);
            v5_reg   <= v4_reg;

            r6_reg   <= l05_reg + fmul(v5_reg, l15_reg - l05_reg) + sv_t'(OFF);

            val      <= vnext[F+3:0];
        end
    end
endmodule

// ===== src/fbm_accum.sv =====
// Per-octave weight and accumulate: sum_out = sum_in + floor(val*amp / ONE) when use_oct, else sum_in.
module fbm_accum #(
    parameter int FRAC_BITS = 16,
    parameter int SUM_W = 28
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic                         use_oct,
    input  logic signed [FRAC_BITS+3:0]  val,
    input  logic [FRAC_BITS:0]           amp,
    input  logic signed [SUM_W-1:0]      sum_in,
    output logic signed [SUM_W-1:0]      sum_out
);
    localparam int PW = 2 * FRAC_BITS + 6;
    logic signed [PW-1:0] prod;
    assign prod = PW'(val) * PW'(signed'({1'b0, amp}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_out <= use_oct ? sum_in + SUM_W'(prod >>> FRAC_BITS) : sum_in;
        end
    end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    // pipeline depth given in the core header
    localparam int PIPE_LATENCY = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int FRAC         = 16;
    localparam longint ONE      = 64'sd1 << FRAC;
    localparam int OCT_MAX      = 8;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] z;
    } coord_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [fbm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fbm_pkg::CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] x_coord;
    logic signed [31:0] z_coord;
    logic out_valid;
    logic out_stall;
    logic signed [fbm_pkg::OUT_W-1:0] noise_sum;

    fbm_gradient_noise_2d_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_coord   (x_coord),
        .z_coord   (z_coord),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .noise_sum (noise_sum)
    );

    // predictor's own copy of the registers
    logic [3:0]  oct_shadow;
    logic [15:0] rough_shadow;

    coord_t coord_q[$];                          // coordinates waiting to be driven
    logic [fbm_pkg::OUT_W-1:0] sum_q[$];         // predicted noise sums, oldest first

    int  cycle_cnt;
    int  err_cnt;
    int  sent_cnt;
    int  recv_cnt;
    bit  idle_mode;                      // random idling on both sides
    bit  hold_send;                      // sender pause requested

    // ---------------- prediction ----------------
    // product of two Q16 values, floored
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic longint fade(longint t);
        longint inner;
        longint t3;
        inner = qmul(t, 6 * t - 15 * ONE) + 10 * ONE;
        t3 = qmul(qmul(t, t), t);
        return qmul(t3, inner);
    endfunction

    function automatic longint grad(logic [7:0] hv, longint dx, longint dz);
        logic [3:0] h;
        longint u;
        longint v;
        h = hv[3:0];
        u = (h < 8) ? dx : dz;
        v = (h < 4) ? dz : ((h == 12 || h == 14) ? dx : 0);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // ROM contents taken as data from the package table; hashing done here
    function automatic longint octave_noise(logic [23:0] xs, logic [23:0] zs);
        logic [7:0] cx, cz, a, b;
        logic [7:0] haa, hab, hba, hbb;
        longint fx, fz, u, v, lo, hi, res, off, rcp, n;
        cx = xs[23:16];
        cz = zs[23:16];
        fx = longint'(xs[15:0]);
        fz = longint'(zs[15:0]);
        a = fbm_pkg::perm_at(cx) + cz;
        b = fbm_pkg::perm_at(cx + 8'd1) + cz;
        haa = fbm_pkg::perm_at(fbm_pkg::perm_at(a));
        hab = fbm_pkg::perm_at(fbm_pkg::perm_at(a + 8'd1));
        hba = fbm_pkg::perm_at(fbm_pkg::perm_at(b));
        hbb = fbm_pkg::perm_at(fbm_pkg::perm_at(b + 8'd1));
        u = fade(fx);
        v = fade(fz);
        lo = grad(haa, fx, fz);
        lo = lo + qmul(u, grad(hba, fx - ONE, fz) - lo);
        hi = grad(hab, fx, fz - ONE);
        hi = hi + qmul(u, grad(hbb, fx - ONE, fz - ONE) - hi);
        res = lo + qmul(v, hi - lo);
        off = ((longint'(69) << FRAC) + 50) / 100;
        rcp = ((longint'(1000) << FRAC) + 741) / 1483;
        n = qmul(res + off, rcp);
        return 2 * n - ONE;
    endfunction

    function automatic logic [fbm_pkg::OUT_W-1:0] predict_sum(coord_t c);
        int cnt;
        longint amp;
        longint total;
        logic [23:0] xs, zs;
        cnt = (oct_shadow > OCT_MAX) ? OCT_MAX : oct_shadow;
        amp = ONE;
        total = 0;
        for (int i = 0; i < cnt; i++)
        begin
            xs = c.x[23:0] << i;
            zs = c.z[23:0] << i;
            total += qmul(octave_noise(xs, zs), amp);
            amp = (amp * longint'(rough_shadow)) >>> 16;
        end
        if (total > 2097151) total = 2097151;
        if (total < -2097152) total = -2097152;
        return total[fbm_pkg::OUT_W-1:0];
    endfunction

    // append one coordinate pair to the send queue
    function automatic void add_coord(logic [31:0] x, logic [31:0] z);
        coord_t c;
        c.x = x;
        c.z = z;
        coord_q = {coord_q, c};
    endfunction

    // ---------------- clock and watchdog ----------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("fbm_gradient_noise_2d_core: mismatch");
            $finish;
        end
    end

    // ---------------- driver ----------------
    // a new coordinate goes out only after the current one transferred
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            sum_q = {sum_q, predict_sum('{x: x_coord, z: z_coord})};
            sent_cnt <= sent_cnt + 1;
        end
        if (!in_valid || !in_stall)
        begin
            if (coord_q.size() > 0 && !hold_send &&
                !(idle_mode && $urandom_range(99) < 34))
            begin
                coord_t c;
                c = coord_q.pop_front();
                in_valid <= 1'b1;
                x_coord  <= c.x;
                z_coord  <= c.z;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        out_stall <= idle_mode && ($urandom_range(99) < 34);
        if (out_valid && !out_stall)
        begin
            recv_cnt <= recv_cnt + 1;
            if (sum_q.size() == 0)
            begin
                err_cnt = err_cnt + 1;
                if (err_cnt <= 10)
                    $display("unexpected noise_sum %0d", noise_sum);
            end
            else
            begin
                logic [fbm_pkg::OUT_W-1:0] want;
                want = sum_q.pop_front();
                if (want !== noise_sum)
                begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10)
                        $display("noise_sum: expected %0d, got %0d",
                                 $signed(want), noise_sum);
                end
            end
        end
    end

    // ---------------- sequencing ----------------
    task automatic wait_drained();
        while (coord_q.size() > 0 || in_valid || sum_q.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [fbm_pkg::CFG_IDX_W-1:0] idx,
                             logic [fbm_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == fbm_pkg::REG_OCTAVE_COUNT)
            oct_shadow = val[3:0];
        else if (idx == fbm_pkg::REG_ROUGHNESS)
            rough_shadow = val;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return {16'($urandom), 16'($urandom_range(1))};
            3: return {16'($urandom_range(511) - 256), 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_batch(int n);
        for (int i = 0; i < n; i++)
            add_coord(rand_coord(), rand_coord());
    endtask

    initial
    begin
        cycle_cnt = 0; err_cnt = 0; sent_cnt = 0; recv_cnt = 0;
        idle_mode = 1'b0; hold_send = 1'b0;
        oct_shadow = fbm_pkg::OCT_RESET;
        rough_shadow = fbm_pkg::ROUGH_RESET;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; x_coord = '0; z_coord = '0;
        out_stall = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, corners of the coordinate space
        add_coord(32'h0, 32'h0);
        add_coord(32'h7fff_ffff, 32'h7fff_ffff);
        add_coord(32'h8000_0000, 32'h8000_0000);
        add_coord(32'hffff_ffff, 32'h0000_0001);
        add_coord(32'h0000_8000, 32'hffff_8000);
        add_coord(32'h00ff_ffff, 32'h0100_0000);
        add_coord(32'hffff_0000, 32'h5555_aaaa);
        wait_drained();

        // octave count zero and above the max, all-ones and zero roughness
        write_reg(fbm_pkg::REG_OCTAVE_COUNT, 16'd0);
        write_reg(fbm_pkg::REG_ROUGHNESS, 16'hffff);
        add_coord(32'h1234_5678, 32'h9abc_def0);
        add_coord(32'h7fff_ffff, 32'h8000_0000);
        wait_drained();
        write_reg(fbm_pkg::REG_OCTAVE_COUNT, 16'd15);
        add_coord(32'h1234_5678, 32'h9abc_def0);
        add_coord(32'h0000_c000, 32'h0003_4000);
        add_coord(32'haaaa_5555, 32'h5555_aaaa);
        wait_drained();
        write_reg(fbm_pkg::REG_ROUGHNESS, 16'd0);
        add_coord(32'h0001_8000, 32'hfffe_8000);
        add_coord(32'h1234_5678, 32'h9abc_def0);
        wait_drained();

        // random phases over several settings; first one with no idling
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(fbm_pkg::REG_OCTAVE_COUNT, 16'd8);
                    write_reg(fbm_pkg::REG_ROUGHNESS, 16'hffff);
                end
                1:
                begin
                    write_reg(fbm_pkg::REG_OCTAVE_COUNT, 16'd1);
                    write_reg(fbm_pkg::REG_ROUGHNESS, 16'd0);
                end
                2:
                begin
                    write_reg(fbm_pkg::REG_OCTAVE_COUNT, 16'd4);
                    write_reg(fbm_pkg::REG_ROUGHNESS, 16'd32768);
                end
                default:
                begin
                    write_reg(fbm_pkg::REG_OCTAVE_COUNT, 16'($urandom_range(15)));
                    write_reg(fbm_pkg::REG_ROUGHNESS, 16'($urandom));
                end
            endcase
            idle_mode = (ph != 0);
            random_batch(100);
            // in phase 3, pause the sender mid-phase until all results are back
            while (coord_q.size() > 0) @(posedge clk);
            if (ph == 3)
            begin
                hold_send = 1'b1;
                while (in_valid || sum_q.size() > 0) @(posedge clk);
                hold_send = 1'b0;
            end
            random_batch(100);
            wait_drained();
        end

        $display("covered %0d coordinate transfers, %0d results, over several",
                 sent_cnt, recv_cnt);
        $display("octave and roughness settings including both extremes");
        if (err_cnt == 0 && sum_q.size() == 0)
            $display("fbm_gradient_noise_2d_core: match");
        else
            $display("fbm_gradient_noise_2d_core: mismatch");
        $finish;
    end

endmodule

// ===== fbm_gradient_noise_2d_core.f =====
src/fbm_pkg.sv
src/fbm_octave.sv
src/fbm_accum.sv
src/fbm_gradient_noise_2d_core.sv
dv/tb_top.sv
